FILE: rtl/cigar_pkg.sv
package cigar_pkg;

   localparam int unsigned MAX_ENTRIES = 64;

   localparam int unsigned LOC_W    = 32;
   localparam int unsigned HALF_W   = 16;
   localparam int unsigned LEN_W    = 32;
   localparam int unsigned ANCHOR_W = 34;
   localparam int unsigned GAP_W    = 35;
   localparam int unsigned COUNT_W  = 8;
   localparam int unsigned IDX_W    = 3;

   typedef enum logic [1:0] {
      OP_M = 2'd0,
      OP_N = 2'd1,
      OP_U = 2'd2
   } op_code_type;

   // Everything one segment produced, waiting to be sent one entry at a time.
   typedef struct packed {
      logic                has_gap;
      logic                has_final;
      logic [IDX_W-1:0]    last_idx;
      logic [LEN_W-1:0]    gap_m_len;
      logic [LEN_W-1:0]    gap_len;
      logic [LEN_W-1:0]    accum;
      logic [HALF_W-1:0]   ext;
      logic [HALF_W-1:0]   mapped_len;
      logic                use_mapped;
      logic [COUNT_W-1:0]  base_count;
   } bundle_type;

endpackage

FILE: rtl/cigar_builder_from_segment_matches.sv
// An accepted segment waits in the pending-entry register until its entries move to the
// output register. Throughput: one segment per cycle if it yields at most one entry and
// the output is not stalled; a segment with a reference gap yields up to five entry words,
// sent one per cycle if unstalled, and holds req_tready low until its last entry moves out.
// Reset: synchronous, active high; clears the anchor, match length, entry count and all
// valid flags.
module cigar_builder_from_segment_matches (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [31:0] ref_location, [47:32] seg_offset, [63:48] seg_length,
   // [79:64] read_length, [95:80] mapped_len
   input  logic [95:0] req_tdata,
   // [0] strand
   input  logic [0:0]  req_tuser,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] op_length
   output logic [31:0] rsp_tdata,
   // [1:0] op_code, [2] overflow
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast
);

   localparam int unsigned HW = cigar_pkg::HALF_W;
   localparam int unsigned LW = cigar_pkg::LEN_W;
   localparam int unsigned GW = cigar_pkg::GAP_W;
   localparam int unsigned AW = cigar_pkg::ANCHOR_W;
   localparam int unsigned CW = cigar_pkg::COUNT_W;
   localparam int unsigned XW = cigar_pkg::IDX_W;

   // Segment state
   logic signed [AW-1:0] prev_anchor_ff, prev_anchor_in;
   logic [LW-1:0]        match_accum_ff, match_accum_in;
   logic [CW-1:0]        entry_count_ff, entry_count_in;
   logic                 started_ff, started_in;

   // Pending entries of one segment
   logic                   bnd_valid_ff, bnd_valid_in;
   cigar_pkg::bundle_type  bnd_ff, bnd_in;
   logic [XW-1:0]          idx_ff, idx_in;

   // Output register
   logic                   out_valid_ff, out_valid_in;
   cigar_pkg::op_code_type out_op_ff, out_op_in;
   logic [LW-1:0]          out_len_ff, out_len_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_ovf_ff, out_ovf_in;

   // Input decode
   logic [cigar_pkg::LOC_W-1:0] loc;
   logic [HW-1:0]  off, seg_len, rlen, mlen;
   logic           rev, last_seg, accept;
   logic signed [GW-1:0] anchor, gap;
   logic           gap_pos;
   logic [LW-1:0]  glen;
   logic [HW:0]    seg_end;
   logic [HW-1:0]  ext;
   logic [LW:0]    accum_sum;
   logic [LW-1:0]  accum_new;
   logic [XW-1:0]  n_new;
   logic [CW:0]    count_sum;

   // Output side
   logic           move, bnd_done;
   logic [XW-1:0]  pos;
   logic [LW:0]    final_sum;
   logic [LW-1:0]  final_len;
   logic [CW:0]    ordinal_base;

   assign loc      = req_tdata[31:0];
   assign off      = req_tdata[47:32];
   assign seg_len  = req_tdata[63:48];
   assign rlen     = req_tdata[79:64];
   assign mlen     = req_tdata[95:80];
   assign rev      = req_tuser[0];
   assign last_seg = req_tlast;

   assign move     = bnd_valid_ff && (!out_valid_ff || rsp_tready);
   assign bnd_done = move && (idx_ff == bnd_ff.last_idx);
   assign req_tready = !bnd_valid_ff || bnd_done;
   assign accept   = req_tvalid && req_tready;

   always_comb begin
      anchor = rev ? (GW'(loc) + GW'(off)) : (GW'(loc) - GW'(off));
      gap    = rev ? (GW'(prev_anchor_ff) - anchor) : (anchor - GW'(prev_anchor_ff));
      gap_pos = started_ff && !gap[GW-1] && (gap != '0);
      glen   = (gap[GW-2:LW] != '0) ? '1 : gap[LW-1:0];

      seg_end = (HW+1)'(off) + (HW+1)'(seg_len);
      ext     = ((HW+1)'(rlen) > seg_end) ? HW'((HW+1)'(rlen) - seg_end) : '0;

      accum_sum = (LW+1)'(match_accum_ff) + (LW+1)'(seg_len);
      if (!started_ff) begin
         accum_new = LW'(seg_end);
      end else if (gap_pos) begin
         accum_new = LW'(seg_len);
      end else begin
         accum_new = accum_sum[LW] ? '1 : accum_sum[LW-1:0];
      end

      n_new     = (gap_pos ? XW'(4) : '0) + (last_seg ? XW'(1) : '0);
      count_sum = (CW+1)'(entry_count_ff) + (CW+1)'(n_new);

      bnd_in.has_gap    = gap_pos;
      bnd_in.has_final  = last_seg;
      bnd_in.last_idx   = n_new - XW'(1);
      bnd_in.gap_m_len  = match_accum_ff;
      bnd_in.gap_len    = glen;
      bnd_in.accum      = accum_new;
      bnd_in.ext        = ext;
      bnd_in.mapped_len = mlen;
      bnd_in.use_mapped = (entry_count_ff == '0) && !gap_pos;
      bnd_in.base_count = entry_count_ff;
   end

   always_comb begin
      prev_anchor_in = prev_anchor_ff;
      match_accum_in = match_accum_ff;
      entry_count_in = entry_count_ff;
      started_in     = started_ff;
      if (accept) begin
         if (last_seg) begin
            // The read ends here: the next segment opens a new read.
            prev_anchor_in = '0;
            match_accum_in = '0;
            entry_count_in = '0;
            started_in     = 1'b0;
         end else begin
            prev_anchor_in = AW'(anchor);
            match_accum_in = accum_new;
            entry_count_in = count_sum[CW] ? '1 : count_sum[CW-1:0];
            started_in     = 1'b1;
         end
      end
   end

   always_comb begin
      bnd_valid_in = bnd_valid_ff;
      idx_in       = idx_ff;
      if (move) begin
         idx_in = idx_ff + XW'(1);
      end
      if (bnd_done) begin
         bnd_valid_in = 1'b0;
      end
      if (accept && (n_new != '0)) begin
         bnd_valid_in = 1'b1;
         idx_in       = '0;
      end
   end

   always_comb begin
      // Without a gap the only entry is the closing M, which sits at position four.
      pos       = bnd_ff.has_gap ? idx_ff : (idx_ff + XW'(4));
      final_sum = (LW+1)'(bnd_ff.accum) + (LW+1)'(bnd_ff.ext);
      if (bnd_ff.use_mapped) begin
         final_len = LW'(bnd_ff.mapped_len);
      end else begin
         final_len = final_sum[LW] ? '1 : final_sum[LW-1:0];
      end
      ordinal_base = (CW+1)'(bnd_ff.base_count) + (CW+1)'(idx_ff);

      out_valid_in = out_valid_ff;
      out_op_in    = out_op_ff;
      out_len_in   = out_len_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (move) begin
         out_valid_in = 1'b1;
         out_last_in  = 1'b0;
         out_ovf_in   = (ordinal_base >= (CW+1)'(cigar_pkg::MAX_ENTRIES));
         case (pos)
            XW'(0): begin
               out_op_in  = cigar_pkg::OP_M;
               out_len_in = bnd_ff.gap_m_len;
            end
            XW'(2): begin
               out_op_in  = cigar_pkg::OP_N;
               out_len_in = bnd_ff.gap_len;
            end
            XW'(4): begin
               out_op_in   = cigar_pkg::OP_M;
               out_len_in  = final_len;
               out_last_in = 1'b1;
            end
            default: begin
               out_op_in  = cigar_pkg::OP_U;
               out_len_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_anchor_ff <= '0;
         match_accum_ff <= '0;
         entry_count_ff <= '0;
         started_ff     <= 1'b0;
         bnd_valid_ff   <= 1'b0;
         idx_ff         <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         prev_anchor_ff <= prev_anchor_in;
         match_accum_ff <= match_accum_in;
         entry_count_ff <= entry_count_in;
         started_ff     <= started_in;
         bnd_valid_ff   <= bnd_valid_in;
         idx_ff         <= idx_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         bnd_ff <= bnd_in;
      end
      out_op_ff   <= out_op_in;
      out_len_ff  <= out_len_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_len_ff;
   assign rsp_tuser  = {out_ovf_ff, out_op_ff};
   assign rsp_tlast  = out_last_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      bnd_valid_ff |-> (idx_ff <= bnd_ff.last_idx))
      else $error("entry index ran past the last pending entry");

   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (out_op_ff == cigar_pkg::OP_U)) |-> (rsp_tdata == '0))
      else $error("marker entry with nonzero length");

   a_last_is_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (out_op_ff == cigar_pkg::OP_M))
      else $error("final entry is not a match entry");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_tready && bnd_valid_ff) |-> bnd_done)
      else $error("new segment taken while entries still pending");

endmodule

FILE: verif/cigar_checker.sv
module cigar_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      cigar_pkg::op_code_type           op;
      logic [cigar_pkg::LEN_W-1:0]      len;
      logic                             last;
      logic                             ovf;
   } cigar_entry_type;

   cigar_entry_type cigar_entry_q[$];

   // Running state of the read being assembled.
   logic signed [cigar_pkg::ANCHOR_W-1:0] last_anchor;
   logic [cigar_pkg::LEN_W-1:0]           run_len;
   logic [cigar_pkg::COUNT_W-1:0]         entries;
   logic                                  in_read;

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= PRINT_LIMIT) begin
         $display("%0t ns cigar_checker: %s", $realtime, what);
      end
   endtask

   function automatic logic [cigar_pkg::LEN_W-1:0] sat_sum(
         input logic [cigar_pkg::LEN_W-1:0] a,
         input logic [cigar_pkg::LEN_W-1:0] b);
      logic [cigar_pkg::LEN_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[cigar_pkg::LEN_W] ? '1 : s[cigar_pkg::LEN_W-1:0];
   endfunction

   task automatic add_entry(input cigar_pkg::op_code_type op,
                            input logic [cigar_pkg::LEN_W-1:0] len,
                            input logic last);
      cigar_entry_type e;
      e.op   = op;
      e.len  = len;
      e.last = last;
      // The flag goes by this entry's position in the CIGAR, counted from one.
      e.ovf  = (int'(entries) + 1) > int'(cigar_pkg::MAX_ENTRIES);
      cigar_entry_q.push_back(e);
      if (entries != '1) begin
         entries = entries + 1'b1;
      end
   endtask

   task automatic build_cigar_entries(input logic [31:0] loc, input logic [15:0] off,
                                      input logic [15:0] len, input logic rev,
                                      input logic [15:0] rlen, input logic [15:0] mlen,
                                      input logic last);
      longint here;
      longint gap;
      logic [cigar_pkg::LEN_W-1:0] gap_len;
      logic [cigar_pkg::LEN_W-1:0] tail;
      logic [cigar_pkg::LEN_W-1:0] final_len;
      logic [16:0] seg_end;
      here = rev ? longint'(loc) + longint'(off) : longint'(loc) - longint'(off);
      if (!in_read) begin
         run_len = 32'(off) + 32'(len);
         in_read = 1'b1;
      end else begin
         gap = rev ? longint'(last_anchor) - here : here - longint'(last_anchor);
         if (gap > 0) begin
            gap_len = (gap > longint'(32'hFFFF_FFFF)) ? '1 : gap[31:0];
            add_entry(cigar_pkg::OP_M, run_len, 1'b0);
            add_entry(cigar_pkg::OP_U, '0, 1'b0);
            add_entry(cigar_pkg::OP_N, gap_len, 1'b0);
            add_entry(cigar_pkg::OP_U, '0, 1'b0);
            run_len = 32'(len);
         end else begin
            run_len = sat_sum(run_len, 32'(len));
         end
      end
      last_anchor = here[cigar_pkg::ANCHOR_W-1:0];
      if (last) begin
         seg_end   = {1'b0, off} + {1'b0, len};
         tail      = ({1'b0, rlen} > seg_end) ? 32'({1'b0, rlen} - seg_end) : '0;
         final_len = (entries == '0) ? 32'(mlen) : sat_sum(run_len, tail);
         add_entry(cigar_pkg::OP_M, final_len, 1'b1);
         last_anchor = '0;
         run_len     = '0;
         entries     = '0;
         in_read     = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      cigar_entry_type exp_entry;
      if (reset) begin
         last_anchor = '0;
         run_len     = '0;
         entries     = '0;
         in_read     = 1'b0;
         cigar_entry_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            build_cigar_entries(req_tdata[31:0], req_tdata[47:32], req_tdata[63:48],
                                req_tuser[0], req_tdata[79:64], req_tdata[95:80],
                                req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (cigar_entry_q.size() == 0) begin
               report_mismatch($sformatf("entry word with nothing expected: op %0d len %0d",
                                         rsp_tuser[1:0], rsp_tdata));
            end else begin
               exp_entry = cigar_entry_q.pop_front();
               if (rsp_tuser[1:0] !== exp_entry.op) begin
                  report_mismatch($sformatf("op_code got %0d expected %0d",
                                            rsp_tuser[1:0], exp_entry.op));
               end
               if (rsp_tdata !== exp_entry.len) begin
                  report_mismatch($sformatf("op_length got %0d expected %0d",
                                            rsp_tdata, exp_entry.len));
               end
               if (rsp_tlast !== exp_entry.last) begin
                  report_mismatch($sformatf("last_entry got %0b expected %0b",
                                            rsp_tlast, exp_entry.last));
               end
               if (rsp_tuser[2] !== exp_entry.ovf) begin
                  report_mismatch($sformatf("overflow got %0b expected %0b",
                                            rsp_tuser[2], exp_entry.ovf));
               end
            end
         end
      end
      pending_count <= cigar_entry_q.size();
   end

endmodule

FILE: verif/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_PCT        = 7;
   localparam int HOLD_CYCLES     = 150;
   localparam int STALL_LIMIT     = 2000;
   localparam int RANDOM_SEGMENTS = 260;
   localparam int GAP_READ_SEGS   = 66;
   localparam int DRAIN_CYCLES    = 12;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   int   fail_count;
   int   pending_count;
   int   seg_count;
   int   stall_cycles;
   int   hold_left;
   logic steady;
   logic hold_go;
   logic hold_done;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   cigar_builder_from_segment_matches u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   cigar_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Output side: random back-pressure, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
         hold_done  <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Offers one segment word and returns at the edge where it is taken.
   task automatic push_segment(input logic [31:0] loc, input logic [15:0] off,
                               input logic [15:0] len, input logic rev,
                               input logic [15:0] rlen, input logic [15:0] mlen,
                               input logic last);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {mlen, rlen, len, off, loc};
      req_tuser  <= rev;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      seg_count++;
   endtask

   // A read of well-formed segments: offsets advance through the read and the
   // anchor moves by a chosen step, so gaps, joins and backward jumps all occur.
   task automatic random_read(input int nseg, input bit all_gaps);
      logic [31:0] anchor;
      logic [31:0] loc;
      logic [15:0] off;
      logic [15:0] len;
      logic [15:0] rlen;
      logic        rev;
      logic        last;
      int unsigned pick;
      int unsigned step;
      rev    = 1'($urandom_range(1));
      anchor = $urandom;
      off    = 16'($urandom_range(40));
      len    = 16'($urandom_range(1, 300));
      for (int i = 0; i < nseg; i++) begin
         if (i > 0) begin
            off  = off + len;
            len  = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 300));
            pick = all_gaps ? 0 : $urandom_range(9);
            if ($urandom_range(9) == 0) begin
               rev = !rev;
            end
            if (pick < 4) begin
               step   = ($urandom_range(7) == 0) ? $urandom : $urandom_range(1, 5000);
               anchor = rev ? anchor - step : anchor + step;
            end else if (pick < 7) begin
               step   = $urandom_range(1, 3000);
               anchor = rev ? anchor + step : anchor - step;
            end
         end
         loc  = rev ? anchor - 32'(off) : anchor + 32'(off);
         last = (i == nseg - 1);
         rlen = ($urandom_range(3) == 0) ? 16'($urandom)
                                         : off + len + 16'($urandom_range(0, 50));
         push_segment(loc, off, len, rev, rlen, 16'($urandom), last);
      end
   endtask

   initial begin
      int unsigned pick;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      req_tlast  <= 1'b0;
      steady     <= 1'b0;
      hold_go    <= 1'b0;
      seg_count  = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single-segment reads at both extremes report the mapped length.
      push_segment('0, '0, '0, 1'b0, '0, '0, 1'b1);
      push_segment('1, '1, '1, 1'b1, '1, '1, 1'b1);
      // Forward anchor below zero, then the widest gap: N saturates.
      push_segment('0, 16'hFFFF, 16'd10, 1'b0, '0, 16'd7, 1'b0);
      push_segment('1, '0, 16'd5, 1'b0, 16'hFFFF, 16'd9, 1'b1);
      // Contiguous forward segments join into one M.
      push_segment(32'd1000, 16'd0, 16'd100, 1'b0, '0, '0, 1'b0);
      push_segment(32'd1100, 16'd100, 16'd50, 1'b0, '0, '0, 1'b0);
      push_segment(32'd1150, 16'd150, 16'd50, 1'b0, 16'd100, 16'd321, 1'b1);
      // Reverse gap, then a forward segment mid-read whose segment ends past the read.
      push_segment(32'd5000, 16'd20, 16'd30, 1'b1, '0, '0, 1'b0);
      push_segment(32'd4000, 16'd60, 16'd40, 1'b1, '0, '0, 1'b0);
      push_segment(32'd4100, 16'd100, 16'd80, 1'b0, 16'd50, 16'd11, 1'b1);
      // Backward jump counts as no gap; a later forward jump opens one.
      push_segment(32'd2000, 16'd0, 16'd10, 1'b0, '0, '0, 1'b0);
      push_segment(32'd1500, 16'd10, 16'd10, 1'b0, '0, '0, 1'b0);
      push_segment(32'd3000, 16'd20, 16'd1, 1'b0, 16'd30, 16'd5, 1'b1);
      // Reverse contiguous, then reverse gap with a zero-length tail.
      push_segment(32'd9000, 16'd0, 16'd40, 1'b1, '0, '0, 1'b0);
      push_segment(32'd8960, 16'd40, 16'd40, 1'b1, '0, '0, 1'b0);
      push_segment(32'd8000, 16'd80, 16'd20, 1'b1, 16'd100, 16'hFFFF, 1'b1);

      // Enough gaps in one read to pass the entry limit and pin the count.
      random_read(GAP_READ_SEGS, 1'b1);
      while (seg_count < RANDOM_SEGMENTS) begin
         if (seg_count > GAP_READ_SEGS + 40 && seg_count < GAP_READ_SEGS + 100) begin
            steady <= 1'b1;
         end else begin
            steady <= 1'b0;
         end
         if (seg_count > GAP_READ_SEGS + 120) begin
            hold_go <= 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 15) begin
            push_segment($urandom, 16'($urandom), 16'($urandom), 1'($urandom),
                         16'($urandom), 16'($urandom), $urandom_range(3) == 0);
         end else begin
            random_read($urandom_range(1, 6), 1'b0);
         end
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: cigar_builder_from_segment_matches.f
rtl/cigar_pkg.sv
rtl/cigar_builder_from_segment_matches.sv
verif/cigar_checker.sv
verif/tb.sv
